FILE: design/pwdc_pkg.sv
package pwdc_pkg;

	// Datagram and ring geometry
	localparam int PULSES_PER_DATAGRAM = 18;
	localparam int RING_SLOTS = 8;

	localparam int DG_W = PULSES_PER_DATAGRAM;
	localparam int CNT_W = (PULSES_PER_DATAGRAM > 1) ? $clog2(PULSES_PER_DATAGRAM) : 1;
	localparam int SLOT_W = $clog2(RING_SLOTS);

	localparam int TIME_W = 32;
	localparam int THR_W = 16;

	// Configuration register indexes and reset values
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_THR = 1'd1;
	localparam logic [THR_W-1:0] SHORT_THR_RST = 16'd200;
	localparam logic [THR_W-1:0] LONG_THR_RST = 16'd440;

	// Request commands
	typedef enum logic [1:0] {
		CMD_LEAD  = 2'd0,
		CMD_TRAIL = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef logic [DG_W-1:0] datagram_t;
	typedef logic [SLOT_W-1:0] slot_t;

endpackage

FILE: design/pulse_width_datagram_collector_core.sv
// Each accepted request places its result in the output register on the next cycle.
// Throughput: one request per cycle; the single result register stalls intake only
// while a result is held and out_ready is low.
// Reset (arst_n low, asynchronous): pulse count, ring slots and leading edge time clear,
// thresholds return to 200 and 440; ring contents are undefined until a datagram commits.
module pulse_width_datagram_collector_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [pwdc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pwdc_pkg::THR_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          command,
	input  logic [pwdc_pkg::TIME_W-1:0]         time_us,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                datagram_valid,
	output logic [pwdc_pkg::DG_W-1:0]           datagram,
	output logic                                available
);
	import pwdc_pkg::*;

	logic [THR_W-1:0]  short_thr_q;
	logic [THR_W-1:0]  long_thr_q;
	logic [TIME_W-1:0] lead_time_q;
	logic [CNT_W-1:0]  pulse_cnt_q;
	slot_t             wr_slot_q;
	slot_t             rd_slot_q;
	datagram_t         asm_q;
	datagram_t         store_q [RING_SLOTS];

	logic              out_valid_q;
	logic              dg_valid_q;
	datagram_t         dg_q;
	logic              avail_q;

	logic              accept;
	logic [TIME_W-1:0] delta;
	logic              gap_long;
	logic              is_short;
	logic              is_long;
	logic              last_pulse;
	logic              commit;
	slot_t             wr_next;
	slot_t             rd_next;
	slot_t             wr_slot_d;
	slot_t             rd_slot_d;
	logic              rd_hit;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	// Measure time since the last leading edge, wrapping at 2^32
	assign delta = time_us - lead_time_q;
	assign gap_long = delta > TIME_W'(long_thr_q);
	assign is_short = delta < TIME_W'(short_thr_q);
	assign is_long = !is_short && (delta < TIME_W'(long_thr_q));
	assign last_pulse = pulse_cnt_q == CNT_W'(PULSES_PER_DATAGRAM - 1);

	assign wr_next = (wr_slot_q == SLOT_W'(RING_SLOTS - 1)) ? '0 : wr_slot_q + 1'b1;
	assign rd_next = (rd_slot_q == SLOT_W'(RING_SLOTS - 1)) ? '0 : rd_slot_q + 1'b1;

	// Commit a full datagram; hold the write slot when the ring is full
	assign commit = accept && (command == CMD_TRAIL) && (is_short || is_long) && last_pulse;
	assign rd_hit = accept && (command == CMD_READ) && (rd_slot_q != wr_slot_q);

	always_comb begin
		wr_slot_d = wr_slot_q;
		rd_slot_d = rd_slot_q;
		if (commit && (wr_next != rd_slot_q)) begin
			wr_slot_d = wr_next;
		end
		if (rd_hit) begin
			rd_slot_d = rd_next;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_thr_q <= SHORT_THR_RST;
			long_thr_q <= LONG_THR_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_SHORT_THR: short_thr_q <= cfg_data;
				CFG_LONG_THR:  long_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Edge tracking, pulse counting and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_time_q <= '0;
			pulse_cnt_q <= '0;
			wr_slot_q <= '0;
			rd_slot_q <= '0;
		end else if (accept) begin
			wr_slot_q <= wr_slot_d;
			rd_slot_q <= rd_slot_d;
			case (command)
				CMD_LEAD: begin
					lead_time_q <= time_us;
					if ((pulse_cnt_q != '0) && gap_long) begin
						pulse_cnt_q <= '0;
					end
				end
				CMD_TRAIL: begin
					if ((is_short || is_long) && !last_pulse) begin
						pulse_cnt_q <= pulse_cnt_q + 1'b1;
					end else begin
						pulse_cnt_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Assemble the datagram for the write slot one pulse bit at a time
	always_ff @(posedge clk) begin
		if (accept && (command == CMD_TRAIL) && (is_short || is_long)) begin
			asm_q[pulse_cnt_q] <= is_long;
		end
	end

	// Store the finished datagram; the write slot is never read before commit
	always_ff @(posedge clk) begin
		if (commit) begin
			store_q[wr_slot_q] <= {is_long, asm_q[DG_W-2:0]};
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dg_valid_q <= rd_hit;
			dg_q <= rd_hit ? store_q[rd_slot_q] : '0;
			avail_q <= rd_slot_d != wr_slot_d;
		end
	end

	assign out_valid = out_valid_q;
	assign datagram_valid = dg_valid_q;
	assign datagram = dg_q;
	assign available = avail_q;

	// Pulse count never reaches a full datagram
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_cnt_q < CNT_W'(PULSES_PER_DATAGRAM))
		else $error("pulse count out of range");

	// A successful read advances the read slot
	a_rd_adv: assert property (@(posedge clk) disable iff (!arst_n)
		rd_hit |=> (rd_slot_q != $past(rd_slot_q)))
		else $error("read slot did not advance");

	// An empty result carries no datagram bits
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !dg_valid_q) |-> (dg_q == '0))
		else $error("datagram bits on empty result");

	// A write slot held by a full ring still leaves data available
	a_full_avail: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && (wr_next == rd_slot_q)) |=> avail_q)
		else $error("full ring reported empty");
endmodule
